// ===== rtl/core/cvxh_pkg.sv =====
// Shared types, constants and helpers of the monotone chain convex hull block.
package cvxh_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned DiffW     = CoordBits + 1;
  localparam int unsigned ProdW     = 2 * DiffW;

  // One point; x sits in the low half, as on the stream buses.
  typedef struct packed {
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } point_t;

  // Sign of the cross product (b - a) x (c - a).
  typedef struct packed {
    logic lt;  // clockwise
    logic gt;  // counter-clockwise
  } orient_t;

  // Lexicographic order: by x, then by y.
  function automatic logic point_before(point_t a, point_t b);
    point_before = (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

// ===== rtl/core/cvxh_orient.sv =====
// Orientation test of three points with registered cross products.
module cvxh_orient (
  input  logic             clk_i,
  input  cvxh_pkg::point_t a_i,
  input  cvxh_pkg::point_t b_i,
  input  cvxh_pkg::point_t c_i,
  output cvxh_pkg::orient_t res_o
);

  logic signed [cvxh_pkg::DiffW-1:0] bx, by, cx, cy;
  logic signed [cvxh_pkg::ProdW-1:0] p_d, q_d, p_q, q_q;

  // Differences and the two products of the cross product.
  always_comb begin
    bx  = cvxh_pkg::DiffW'(b_i.x) - cvxh_pkg::DiffW'(a_i.x);
    by  = cvxh_pkg::DiffW'(b_i.y) - cvxh_pkg::DiffW'(a_i.y);
    cx  = cvxh_pkg::DiffW'(c_i.x) - cvxh_pkg::DiffW'(a_i.x);
    cy  = cvxh_pkg::DiffW'(c_i.y) - cvxh_pkg::DiffW'(a_i.y);
    p_d = cvxh_pkg::ProdW'(bx) * cvxh_pkg::ProdW'(cy);
    q_d = cvxh_pkg::ProdW'(by) * cvxh_pkg::ProdW'(cx);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    q_q <= q_d;
  end

  // Compare of the registered products.
  assign res_o.lt = (p_q < q_q);
  assign res_o.gt = (p_q > q_q);

endmodule

// ===== rtl/core/convex_hull_monotone_chain.sv =====
// Top level of the monotone chain convex hull block.
// Points arrive one per transaction; tlast marks the final point of a set, after which
// the block emits the hull: lower chain left to right, then the upper chain right to
// left without its endpoints, with tlast on the final vertex and tuser set when points
// beyond the 64-entry store were dropped. Each point is placed by insertion into a
// sorted point memory, shifting each larger entry up one place before the next point
// can be taken. The hull is then built one chain at a time through a stack memory: a
// point is skipped, or pushed after popping every top entry that with it makes no turn
// the chain's way. Each vertex is read from the stack and sent when the output is not
// held off. Input is not taken while a point is sorted or a hull is built and sent.
module convex_hull_monotone_chain (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] point_x, [31:16] point_y
  input  logic        s_axis_tlast_i,   // set_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] hull_x, [31:16] hull_y
  output logic        m_axis_tlast_o,   // hull_last
  output logic        m_axis_tuser_o    // overflowed
);

  localparam int unsigned IdxW = cvxh_pkg::IdxW;
  localparam int unsigned CntW = cvxh_pkg::CntW;

  typedef enum logic [15:0] {
    S_LOAD     = 16'h0001,
    S_SORT_RD  = 16'h0002,
    S_SORT_CMP = 16'h0004,
    S_H_RD0    = 16'h0008,
    S_H_RD1    = 16'h0010,
    S_H_RDN    = 16'h0020,
    S_C_INIT   = 16'h0040,
    S_C_RD     = 16'h0080,
    S_C_FILT   = 16'h0100,
    S_C_FILTW  = 16'h0200,
    S_POP_CHK  = 16'h0400,
    S_POP_ORI  = 16'h0800,
    S_POP_DEC  = 16'h1000,
    S_NEXT     = 16'h2000,
    S_OUT_RD   = 16'h4000,
    S_OUT_LD   = 16'h8000
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q, d_q, ld_q;
  logic [IdxW-1:0] j_q, i_q, k_q;
  logic ovf_q, last_q, upper_q, out_upper_q, single_q;
  cvxh_pkg::point_t key_q, first_q, final_q, c_q, tp_q, a_q;

  // Point memory and chain stack memory.
  cvxh_pkg::point_t pmem [cvxh_pkg::MaxPoints];
  cvxh_pkg::point_t cmem [2*cvxh_pkg::MaxPoints];
  cvxh_pkg::point_t srd_q, crd_q;
  logic             s_we, s_re, c_we, c_re;
  logic [IdxW-1:0]  s_waddr, s_raddr;
  logic [IdxW:0]    c_waddr, c_raddr;
  cvxh_pkg::point_t s_wdata, c_wdata;

  cvxh_pkg::point_t  o_a, o_b, o_c;
  cvxh_pkg::orient_t ores;
  logic              turn, at_end, in_acc, out_free, push;
  logic [IdxW-1:0]   n_last;
  logic [CntW-1:0]   d_m2, ld_m1;

  logic        ov_q, olast_q, oovf_q;
  cvxh_pkg::point_t odata_q;

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = !ov_q || m_axis_tready_i;
  assign n_last   = IdxW'(count_q - CntW'(1));
  assign at_end   = (i_q == n_last);
  assign d_m2     = d_q - CntW'(2);
  assign ld_m1    = ld_q - CntW'(1);
  // Clockwise turn for the lower chain, counter-clockwise for the upper one.
  assign turn     = upper_q ? ores.gt : ores.lt;
  assign push     = ((state_q == S_POP_CHK) && (d_q < CntW'(2))) ||
                    ((state_q == S_POP_DEC) && turn);

  cvxh_orient u_orient (
    .clk_i (clk_i),
    .a_i   (o_a),
    .b_i   (o_b),
    .c_i   (o_c),
    .res_o (ores)
  );

  // Operand selection for the orientation unit.
  always_comb begin
    if (state_q == S_C_FILT) begin
      o_a = first_q;
      o_b = srd_q;
      o_c = final_q;
    end else begin
      o_a = crd_q;
      o_b = tp_q;
      o_c = c_q;
    end
  end

  // Memory port control.
  always_comb begin
    s_we    = 1'b0;
    s_waddr = j_q;
    s_wdata = key_q;
    s_re    = 1'b0;
    s_raddr = i_q;
    c_we    = 1'b0;
    c_waddr = {upper_q, d_q[IdxW-1:0]};
    c_wdata = c_q;
    c_re    = 1'b0;
    c_raddr = {upper_q, d_m2[IdxW-1:0]};
    case (state_q)
      S_SORT_RD: begin
        if (j_q == '0) begin
          s_we = 1'b1;
        end else begin
          s_re    = 1'b1;
          s_raddr = j_q - IdxW'(1);
        end
      end
      S_SORT_CMP: begin
        s_we = 1'b1;
        if (cvxh_pkg::point_before(key_q, srd_q)) begin
          s_wdata = srd_q;
        end
      end
      S_H_RD0: begin
        s_re    = 1'b1;
        s_raddr = '0;
      end
      S_H_RD1: begin
        s_re    = 1'b1;
        s_raddr = n_last;
      end
      S_C_RD: begin
        s_re = 1'b1;
      end
      S_C_INIT: begin
        c_we    = 1'b1;
        c_waddr = {upper_q, {IdxW{1'b0}}};
        c_wdata = first_q;
      end
      S_POP_CHK: begin
        c_re = (d_q >= CntW'(2));
        c_we = push;
      end
      S_POP_DEC: begin
        c_we = push;
      end
      S_OUT_RD: begin
        c_re    = 1'b1;
        c_raddr = {out_upper_q, k_q};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) pmem[s_waddr] <= s_wdata;
    if (s_re) srd_q <= pmem[s_raddr];
    if (c_we) cmem[c_waddr] <= c_wdata;
    if (c_re) crd_q <= cmem[c_raddr];
  end

  // Output valid: set when a vertex is loaded, cleared when it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if ((state_q == S_OUT_LD) && out_free) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ov_q <= 1'b0;
    end
  end

  // Sequencer: load and sort, chain building, vertex emission.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      d_q         <= '0;
      ld_q        <= '0;
      j_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      upper_q     <= 1'b0;
      out_upper_q <= 1'b0;
      single_q    <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            last_q <= s_axis_tlast_i;
            if (count_q < CntW'(cvxh_pkg::MaxPoints)) begin
              key_q   <= s_axis_tdata_i;
              j_q     <= count_q[IdxW-1:0];
              state_q <= S_SORT_RD;
            end else begin
              ovf_q <= 1'b1;
              if (s_axis_tlast_i) state_q <= S_H_RD0;
            end
          end
        end
        S_SORT_RD: begin
          if (j_q == '0) begin
            count_q <= count_q + CntW'(1);
            state_q <= last_q ? S_H_RD0 : S_LOAD;
          end else begin
            state_q <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (cvxh_pkg::point_before(key_q, srd_q)) begin
            j_q     <= j_q - IdxW'(1);
            state_q <= S_SORT_RD;
          end else begin
            count_q <= count_q + CntW'(1);
            state_q <= last_q ? S_H_RD0 : S_LOAD;
          end
        end
        S_H_RD0: state_q <= S_H_RD1;
        S_H_RD1: begin
          first_q <= srd_q;
          state_q <= S_H_RDN;
        end
        S_H_RDN: begin
          final_q <= srd_q;
          upper_q <= 1'b0;
          if ((count_q == CntW'(1)) || (first_q == srd_q)) begin
            single_q <= 1'b1;
            state_q  <= S_OUT_LD;
          end else begin
            single_q <= 1'b0;
            state_q  <= S_C_INIT;
          end
        end
        S_C_INIT: begin
          tp_q    <= first_q;
          d_q     <= CntW'(1);
          i_q     <= IdxW'(1);
          state_q <= S_C_RD;
        end
        S_C_RD: state_q <= S_C_FILT;
        S_C_FILT: begin
          c_q     <= srd_q;
          state_q <= S_C_FILTW;
        end
        S_C_FILTW: begin
          state_q <= (at_end || turn) ? S_POP_CHK : S_NEXT;
        end
        S_POP_CHK: begin
          if (push) begin
            tp_q    <= c_q;
            d_q     <= d_q + CntW'(1);
            state_q <= S_NEXT;
          end else begin
            state_q <= S_POP_ORI;
          end
        end
        S_POP_ORI: begin
          a_q     <= crd_q;
          state_q <= S_POP_DEC;
        end
        S_POP_DEC: begin
          if (push) begin
            tp_q    <= c_q;
            d_q     <= d_q + CntW'(1);
            state_q <= S_NEXT;
          end else begin
            tp_q    <= a_q;
            d_q     <= d_q - CntW'(1);
            state_q <= S_POP_CHK;
          end
        end
        S_NEXT: begin
          if (!at_end) begin
            i_q     <= i_q + IdxW'(1);
            state_q <= S_C_RD;
          end else if (!upper_q) begin
            ld_q    <= d_q;
            upper_q <= 1'b1;
            state_q <= S_C_INIT;
          end else begin
            out_upper_q <= 1'b0;
            k_q         <= '0;
            state_q     <= S_OUT_RD;
          end
        end
        S_OUT_RD: state_q <= S_OUT_LD;
        S_OUT_LD: begin
          if (out_free) begin
            oovf_q <= ovf_q;
            if (single_q) begin
              odata_q <= first_q;
              olast_q <= 1'b1;
              state_q <= S_LOAD;
            end else if (!out_upper_q) begin
              odata_q <= crd_q;
              olast_q <= ({1'b0, k_q} == ld_m1) && (d_q <= CntW'(2));
              if ({1'b0, k_q} != ld_m1) begin
                k_q     <= k_q + IdxW'(1);
                state_q <= S_OUT_RD;
              end else if (d_q > CntW'(2)) begin
                out_upper_q <= 1'b1;
                k_q         <= d_m2[IdxW-1:0];
                state_q     <= S_OUT_RD;
              end else begin
                state_q <= S_LOAD;
              end
            end else begin
              odata_q <= crd_q;
              olast_q <= (k_q == IdxW'(1));
              if (k_q == IdxW'(1)) begin
                state_q <= S_LOAD;
              end else begin
                k_q     <= k_q - IdxW'(1);
                state_q <= S_OUT_RD;
              end
            end
            if (single_q || (!out_upper_q && ({1'b0, k_q} == ld_m1) && (d_q <= CntW'(2)))
                || (out_upper_q && (k_q == IdxW'(1)))) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = oovf_q;

  // The store never holds more than its capacity.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(cvxh_pkg::MaxPoints))
    else $error("point count beyond capacity");

  // While a chain is built or read out, its stack never outgrows the stored points.
  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_CHK || state_q == S_POP_ORI || state_q == S_POP_DEC ||
     state_q == S_NEXT || state_q == S_OUT_RD) |-> d_q <= count_q)
    else $error("chain depth beyond point count");

  // A pop decision is only taken with at least two entries on the stack.
  a_pop_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_DEC |-> d_q >= CntW'(2))
    else $error("pop with a short stack");

endmodule

// ===== verif/tb_convex_hull_monotone_chain.sv =====
// Self-checking testbench of the monotone chain convex hull block.
`timescale 1ns / 1ps

module tb_convex_hull_monotone_chain;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned TailCycles = 400;

  // Idling phases.
  typedef enum int {
    PhaseNone,
    PhaseSendIdle,
    PhaseRecvStall,
    PhaseBoth
  } idle_phase_e;

  // Expected hull vertex.
  typedef struct {
    cvxh_pkg::point_t vertex;
    logic             last;
    logic             ovf;
  } vertex_exp_t;

  // One row of the directed table; has_exp marks a typed-in expectation.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               set_end;
    logic               has_exp;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic               elast;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;   // [15:0] point_x, [31:16] point_y
  logic        s_axis_tlast_i = 1'b0; // set_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [15:0] hull_x, [31:16] hull_y
  logic        m_axis_tlast_o;        // hull_last
  logic        m_axis_tuser_o;        // overflowed

  convex_hull_monotone_chain dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state: the set being collected.
  cvxh_pkg::point_t pending_pts[$];
  logic             pending_ovf;
  vertex_exp_t      hull_queue[$];
  int unsigned      mismatches = 0;
  int unsigned      vertices_seen = 0;
  int unsigned      hulls_built = 0;
  int unsigned      cycle_count = 0;
  idle_phase_e      phase = PhaseNone;
  bit               long_hold = 1'b0;

  // Sign of the cross product (b - a) x (c - a).
  function automatic int cross_sign(cvxh_pkg::point_t a, cvxh_pkg::point_t b,
                                    cvxh_pkg::point_t c);
    longint p;
    longint q;
    p = (longint'(b.x) - a.x) * (longint'(c.y) - a.y);
    q = (longint'(b.y) - a.y) * (longint'(c.x) - a.x);
    return (p < q) ? -1 : ((p > q) ? 1 : 0);
  endfunction

  // Appends one expected vertex.
  function automatic void queue_vertex(cvxh_pkg::point_t v, logic last, logic ovf);
    vertex_exp_t e;
    e.vertex = v;
    e.last   = last;
    e.ovf    = ovf;
    hull_queue = {hull_queue, e};
  endfunction

  // Builds the hull of the collected set and queues its vertices.
  task automatic predict_hull();
    cvxh_pkg::point_t pts[$];
    cvxh_pkg::point_t key;
    cvxh_pkg::point_t first_pt;
    cvxh_pkg::point_t final_pt;
    int     lo[$];
    int     up[$];
    int     n;
    int     j;
    bit     tail;
    pts = pending_pts;
    n = pts.size();
    hulls_built++;
    for (int i = 1; i < n; i++) begin
      key = pts[i];
      j = i;
      while (j > 0 && ((key.x < pts[j-1].x) ||
                       (key.x == pts[j-1].x && key.y < pts[j-1].y))) begin
        pts[j] = pts[j-1];
        j--;
      end
      pts[j] = key;
    end
    first_pt = pts[0];
    final_pt = pts[n-1];
    if (n == 1 || first_pt == final_pt) begin
      queue_vertex(first_pt, 1'b1, pending_ovf);
      return;
    end
    lo = {lo, 0};
    up = {up, 0};
    for (int i = 1; i < n; i++) begin
      tail = (i == n - 1);
      if (tail || cross_sign(first_pt, pts[i], final_pt) < 0) begin
        while (lo.size() >= 2 &&
               cross_sign(pts[lo[lo.size()-2]], pts[lo[lo.size()-1]], pts[i]) >= 0)
          lo = lo[0:$-1];
        lo = {lo, i};
      end
      if (tail || cross_sign(first_pt, pts[i], final_pt) > 0) begin
        while (up.size() >= 2 &&
               cross_sign(pts[up[up.size()-2]], pts[up[up.size()-1]], pts[i]) <= 0)
          up = up[0:$-1];
        up = {up, i};
      end
    end
    foreach (lo[i])
      queue_vertex(pts[lo[i]], (i == lo.size() - 1) && up.size() <= 2, pending_ovf);
    for (int i = up.size() - 2; i > 0; i--)
      queue_vertex(pts[up[i]], i == 1, pending_ovf);
  endtask

  // Accepts one point into the predictor.
  task automatic take_point(cvxh_pkg::point_t p, logic set_end);
    if (pending_pts.size() < cvxh_pkg::MaxPoints) pending_pts = {pending_pts, p};
    else pending_ovf = 1'b1;
    if (set_end) begin
      predict_hull();
      pending_pts.delete();
      pending_ovf = 1'b0;
    end
  endtask

  // Drives one point and waits for its transaction; tvalid stays high afterwards.
  task automatic send_point(cvxh_pkg::point_t p, logic set_end);
    int unsigned gap_pct;
    gap_pct = (phase == PhaseSendIdle) ? 51 : ((phase == PhaseBoth) ? 14 : 0);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {p.y, p.x};
    s_axis_tlast_i  <= set_end;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    take_point(p, set_end);
    @(negedge clk_i);
  endtask

  // Ends a burst of points.
  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord(int unsigned span);
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom_range(2 * span) - span);
    endcase
  endfunction

  // Stops sending and waits until every expected vertex has arrived.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (hull_queue.size() != 0);
  endtask

  // Receiver: ready pattern per phase, plus the long hold-off.
  always @(negedge clk_i) begin
    int unsigned stall_pct;
    stall_pct = (phase == PhaseRecvStall) ? 51 : ((phase == PhaseBoth) ? 14 : 0);
    if (long_hold) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Checks each output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    vertex_exp_t      e;
    cvxh_pkg::point_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      vertices_seen++;
      if (hull_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex (%0d,%0d) last=%b ovf=%b", got.x, got.y,
                   m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        e = hull_queue.pop_front();
        if (got !== e.vertex || m_axis_tlast_o !== e.last || m_axis_tuser_o !== e.ovf)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display({"vertex mismatch: expected (%0d,%0d) last=%b ovf=%b, ",
                      "got (%0d,%0d) last=%b ovf=%b"},
                     e.vertex.x, e.vertex.y, e.last, e.ovf, got.x, got.y,
                     m_axis_tlast_o, m_axis_tuser_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("convex_hull_monotone_chain regression: fail");
      $finish;
    end
  end

  // Directed table: extremes, single point, equal points, collinear, repeats.
  dir_row_t dir_rows [17] = '{
    '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, 16'sh7fff, 16'sh8000, 1'b1},
    '{16'sd5, 16'sd5, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd5, 16'sd5, 1'b1, 1'b1, 16'sd5, 16'sd5, 1'b1},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd3, 16'sd3, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{-16'sd2, -16'sd2, 1'b1, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd4, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd2, 16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd2, -16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0},
    '{16'sd2, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'sd0, 1'b0}
  };

  initial begin
    cvxh_pkg::point_t p;
    vertex_exp_t      e;
    int               n;
    pending_ovf = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; a typed-in expectation replaces the predictor's vertex.
    foreach (dir_rows[r]) begin
      p.x = dir_rows[r].x;
      p.y = dir_rows[r].y;
      send_point(p, dir_rows[r].set_end);
      if (dir_rows[r].has_exp) begin
        e.vertex.x = dir_rows[r].ex;
        e.vertex.y = dir_rows[r].ey;
        e.last     = dir_rows[r].elast;
        e.ovf      = 1'b0;
        hull_queue[hull_queue.size() - 1] = e;
      end
    end
    wait_drained();

    // Overflow set: 70 points into a 64-entry store.
    for (int i = 0; i < 70; i++) begin
      p.x = rand_coord(1000);
      p.y = rand_coord(1000);
      send_point(p, i == 69);
    end

    // Long receiver hold-off while points keep coming.
    fork
      begin
        long_hold = 1'b1;
        repeat (600) @(negedge clk_i);
        long_hold = 1'b0;
      end
      begin
        for (int s = 0; s < 4; s++) begin
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++) begin
            p.x = rand_coord(20);
            p.y = rand_coord(20);
            send_point(p, i == n - 1);
          end
        end
        stop_sending();
      end
    join
    wait_drained();

    // Random sets across the idling phases; mostly small sets.
    for (int ph = 0; ph < 4; ph++) begin
      phase = idle_phase_e'(ph);
      for (int s = 0; s < 5; s++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
          p.x = rand_coord(($urandom_range(1)) ? 8 : 30000);
          p.y = rand_coord(($urandom_range(1)) ? 8 : 30000);
          send_point(p, i == n - 1);
        end
        if (s == 2) wait_drained();
      end
      wait_drained();
    end
    phase = PhaseNone;

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    $display("covered %0d hull sets and %0d vertices, including overflow, extremes,",
             hulls_built, vertices_seen);
    $display("degenerate sets, a long output hold-off and four idling phases");
    if (mismatches == 0 && hull_queue.size() == 0) begin
      $display("convex_hull_monotone_chain regression: pass");
    end else begin
      $display("%0d mismatches, %0d vertices outstanding", mismatches, hull_queue.size());
      $display("convex_hull_monotone_chain regression: fail");
    end
    $finish;
  end

endmodule

// ===== convex_hull_monotone_chain.f =====
rtl/core/cvxh_pkg.sv
rtl/core/cvxh_orient.sv
rtl/core/convex_hull_monotone_chain.sv
verif/tb_convex_hull_monotone_chain.sv
